// ----- rtl/pstt_pkg.sv -----
// pstt_pkg: shared types, codes and widths of the periodic timer table
// used by periodic_software_timer_table, pstt_eval and the testbench; depends on nothing
`default_nettype none

package pstt_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);

  localparam int OwnerW   = 16;
  localparam int IdW      = 16;
  localparam int PeriodW  = 24;
  localparam int ElapsedW = 24;
  localparam int StepW    = 16;

  localparam int InDataW  = 56;
  localparam int OutDataW = 40;

  localparam logic [StepW-1:0] TickStepReset = 16'd50;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_REG   = 2'd1,
    CMD_UNREG = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_REG_REPLY   = 2'd0,
    KIND_UNREG_REPLY = 2'd1,
    KIND_EXPIRY      = 2'd2,
    KIND_TICK_DONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // one table row as stored in the entry memory
  typedef struct packed {
    logic [OwnerW-1:0]   owner;
    logic [IdW-1:0]      number;
    logic [PeriodW-1:0]  period;
    logic [ElapsedW-1:0] elapsed;
  } entry_t;

  // per-entry evaluation handed back to the sequencer
  typedef struct packed {
    logic                match;
    logic                fire;
    logic [ElapsedW-1:0] elapsed;
  } eval_t;

endpackage

`default_nettype wire

// ----- rtl/periodic_software_timer_table.sv -----
// periodic_software_timer_table: table of periodic timers in registration order
// depends on pstt_pkg, pstt_ram, pstt_eval
// table walk: each entry visited passes a ram read state, then an evaluate state;
//   a tick walks every entry, a register or unregister search walks up to a
//   match or the tail, and each entry moved to close a gap is read, then written
// throughput: one item at a time; each expiry or reply may also wait on out_tready
// reset: synchronous active-low; clears entry count, sequencer, output valid
//   and sets tick_step to 50; entry memory contents are not cleared
`default_nettype none

module periodic_software_timer_table (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input items
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [15:0] owner, [31:16] tmr_num, [55:32] period
  input  wire logic [pstt_pkg::InDataW-1:0]     in_tdata,
  // [1:0] cmd
  input  wire logic [1:0]                       in_tuser,
  // result items
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [1:0] status, [17:2] fire_owner, [33:18] fire_id, [39:34] zero
  output logic      [pstt_pkg::OutDataW-1:0]    out_tdata,
  // [1:0] kind
  output logic      [1:0]                       out_tuser,
  output logic                                  out_tlast,
  // tick_step write
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [pstt_pkg::StepW-1:0]       cfg_data
);

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,  // waiting for an item
    S_RD    = 7'b0000010,  // read entry idx
    S_EX    = 7'b0000100,  // evaluate entry idx
    S_SR    = 7'b0001000,  // read entry idx+1 for the gap close
    S_SW    = 7'b0010000,  // write it back at idx
    S_FIN   = 7'b0100000,  // walk done: decide reply, append on register
    S_REPLY = 7'b1000000   // hand the final result to the output register
  } state_t;

  state_t state_r, state_nxt;

  // latched item
  pstt_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [pstt_pkg::OwnerW-1:0]      owner_r, owner_nxt;
  logic [pstt_pkg::IdW-1:0]         id_r, id_nxt;
  logic [pstt_pkg::PeriodW-1:0]     period_r, period_nxt;

  // walk position and table fill
  logic [pstt_pkg::IdxW-1:0]        idx_r, idx_nxt;
  logic [pstt_pkg::CntW-1:0]        cnt_r, cnt_nxt;
  pstt_pkg::status_t                rstat_r, rstat_nxt;

  logic [pstt_pkg::StepW-1:0]       tick_step_r;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  pstt_pkg::kind_t                  out_kind_r, out_kind_nxt;
  pstt_pkg::status_t                out_stat_r, out_stat_nxt;
  logic [pstt_pkg::OwnerW-1:0]      out_owner_r, out_owner_nxt;
  logic [pstt_pkg::IdW-1:0]         out_id_r, out_id_nxt;
  logic                             out_last_r, out_last_nxt;

  // memory ports
  logic                             wr_en;
  logic [pstt_pkg::IdxW-1:0]        wr_addr;
  pstt_pkg::entry_t                 wr_ent;
  logic [pstt_pkg::IdxW-1:0]        rd_addr;
  logic [$bits(pstt_pkg::entry_t)-1:0] rd_data;
  pstt_pkg::entry_t                 rd_ent;
  pstt_pkg::eval_t                  ev;

  logic in_acc;
  logic slot_free;
  logic at_last;
  logic next_is_last;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // the output register can take a result when empty or being drained
  assign slot_free = !out_valid_r || out_tready;

  assign at_last      = ((pstt_pkg::CntW'(idx_r) + pstt_pkg::CntW'(1)) == cnt_r);
  assign next_is_last = ((pstt_pkg::CntW'(idx_r) + pstt_pkg::CntW'(2)) == cnt_r);

  // gap close reads one entry ahead of the write position
  assign rd_addr = (state_r == S_SR) ? (idx_r + pstt_pkg::IdxW'(1)) : idx_r;
  assign rd_ent  = pstt_pkg::entry_t'(rd_data);

  pstt_ram #(
    .Width ($bits(pstt_pkg::entry_t)),
    .Depth (pstt_pkg::TableDepth)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pstt_eval u_eval (
    .ent      (rd_ent),
    .step     (tick_step_r),
    .owner    (owner_r),
    .tmr_num  (id_r),
    .res      (ev)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    owner_nxt     = owner_r;
    id_nxt        = id_r;
    period_nxt    = period_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    rstat_nxt     = rstat_r;

    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_stat_nxt  = out_stat_r;
    out_owner_nxt = out_owner_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;

    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_ent  = rd_ent;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = pstt_pkg::cmd_t'(in_tuser);
          owner_nxt  = in_tdata[15:0];
          id_nxt     = in_tdata[31:16];
          period_nxt = in_tdata[55:32];
          idx_nxt    = '0;
          if (pstt_pkg::cmd_t'(in_tuser) inside {pstt_pkg::CMD_TICK, pstt_pkg::CMD_REG,
                                                 pstt_pkg::CMD_UNREG}) begin
            state_nxt = (cnt_r == '0) ? S_FIN : S_RD;
          end
          // command three: dropped without result
        end
      end

      S_RD: begin
        state_nxt = S_EX;
      end

      S_EX: begin
        if (cmd_r == pstt_pkg::CMD_TICK) begin
          // an expiry waits here until the output register frees up
          if (!ev.fire || slot_free) begin
            wr_en          = 1'b1;
            wr_ent.elapsed = ev.elapsed;
            if (ev.fire) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pstt_pkg::KIND_EXPIRY;
              out_stat_nxt  = pstt_pkg::ST_OK;
              out_owner_nxt = rd_ent.owner;
              out_id_nxt    = rd_ent.number;
              out_last_nxt  = 1'b0;
            end
            if (at_last) begin
              state_nxt = S_FIN;
            end else begin
              idx_nxt   = idx_r + pstt_pkg::IdxW'(1);
              state_nxt = S_RD;
            end
          end
        end else if (ev.match) begin
          if (cmd_r == pstt_pkg::CMD_REG) begin
            rstat_nxt = pstt_pkg::ST_DUP;
            state_nxt = S_REPLY;
          end else if (at_last) begin
            // removing the tail entry needs no move
            cnt_nxt   = cnt_r - pstt_pkg::CntW'(1);
            rstat_nxt = pstt_pkg::ST_OK;
            state_nxt = S_REPLY;
          end else begin
            state_nxt = S_SR;
          end
        end else if (at_last) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + pstt_pkg::IdxW'(1);
          state_nxt = S_RD;
        end
      end

      S_SR: begin
        state_nxt = S_SW;
      end

      S_SW: begin
        wr_en = 1'b1;
        if (next_is_last) begin
          cnt_nxt   = cnt_r - pstt_pkg::CntW'(1);
          rstat_nxt = pstt_pkg::ST_OK;
          state_nxt = S_REPLY;
        end else begin
          idx_nxt   = idx_r + pstt_pkg::IdxW'(1);
          state_nxt = S_SR;
        end
      end

      S_FIN: begin
        state_nxt = S_REPLY;
        case (cmd_r)
          pstt_pkg::CMD_REG: begin
            if (cnt_r == pstt_pkg::CntW'(pstt_pkg::TableDepth)) begin
              rstat_nxt = pstt_pkg::ST_FULL;
            end else begin
              // append the new timer at the tail
              wr_en          = 1'b1;
              wr_addr        = cnt_r[pstt_pkg::IdxW-1:0];
              wr_ent.owner   = owner_r;
              wr_ent.number  = id_r;
              wr_ent.period  = period_r;
              wr_ent.elapsed = '0;
              cnt_nxt        = cnt_r + pstt_pkg::CntW'(1);
              rstat_nxt      = pstt_pkg::ST_OK;
            end
          end
          pstt_pkg::CMD_UNREG: begin
            rstat_nxt = pstt_pkg::ST_NOT_FOUND;
          end
          default: begin
            rstat_nxt = pstt_pkg::ST_OK;
          end
        endcase
      end

      S_REPLY: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = rstat_r;
          out_owner_nxt = '0;
          out_id_nxt    = '0;
          out_last_nxt  = 1'b1;
          case (cmd_r)
            pstt_pkg::CMD_REG:   out_kind_nxt = pstt_pkg::KIND_REG_REPLY;
            pstt_pkg::CMD_UNREG: out_kind_nxt = pstt_pkg::KIND_UNREG_REPLY;
            default:             out_kind_nxt = pstt_pkg::KIND_TICK_DONE;
          endcase
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      tick_step_r <= pstt_pkg::TickStepReset;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tick_step_r <= cfg_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    owner_r     <= owner_nxt;
    id_r        <= id_nxt;
    period_r    <= period_nxt;
    idx_r       <= idx_nxt;
    rstat_r     <= rstat_nxt;
    out_kind_r  <= out_kind_nxt;
    out_stat_r  <= out_stat_nxt;
    out_owner_r <= out_owner_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_id_r, out_owner_r, out_stat_r};

endmodule

`default_nettype wire

// ----- rtl/pstt_ram.sv -----
// pstt_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module pstt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
  input  wire logic [Width-1:0]                       wr_data,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
  output logic      [Width-1:0]                       rd_data
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/pstt_eval.sv -----
// pstt_eval: per-entry tick update (saturating add, expiry test) and key match
// depends on pstt_pkg
`default_nettype none

module pstt_eval (
  input  wire pstt_pkg::entry_t              ent,
  input  wire logic [pstt_pkg::StepW-1:0]    step,
  input  wire logic [pstt_pkg::OwnerW-1:0]   owner,
  input  wire logic [pstt_pkg::IdW-1:0]      tmr_num,
  output pstt_pkg::eval_t                    res
);

  logic [pstt_pkg::ElapsedW:0]   sum;
  logic [pstt_pkg::ElapsedW-1:0] sat;
  logic                          fire;

  always_comb begin
    sum  = {1'b0, ent.elapsed} + (pstt_pkg::ElapsedW + 1)'(step);
    sat  = sum[pstt_pkg::ElapsedW] ? '1 : sum[pstt_pkg::ElapsedW-1:0];
    // unowned entries never fire
    fire = (ent.owner != '0) && (sat >= ent.period);
    res.fire    = fire;
    res.elapsed = fire ? '0 : sat;
    res.match   = (ent.owner == owner) && (ent.number == tmr_num);
  end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// testbench: self-checking bench for the periodic timer table, with a directed table
// walk, a full-table pass and a random command mix
// depends on pstt_pkg and periodic_software_timer_table
`timescale 1ns / 1ps

module testbench;
  import pstt_pkg::*;

  localparam int  RAND_ITEMS = 275;
  // enough to cover a full tick walk plus a full gap close
  localparam int  SETTLE     = 80;
  localparam time LIMIT      = 10_000_000;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [15:0] fire_owner;
    logic [15:0] fire_id;
    logic        last;
  } result_t;

  typedef struct packed {
    bit          is_cfg;
    logic [15:0] step;
    cmd_t        cmd;
    logic [15:0] owner;
    logic [15:0] number;
    logic [23:0] period;
    bit          typed;
    kind_t       kind;
    status_t     status;
  } dir_row_t;

  // directed walk; typed rows carry their reply, the rest go through the predictor
  localparam int DIR_ROWS = 19;
  localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
    // empty table: tick gives only the done item
    '{1'b0, 16'd0,     CMD_TICK,  16'h0000, 16'h0000, 24'h000000, 1'b1, KIND_TICK_DONE,   ST_OK},
    // unknown unregister
    '{1'b0, 16'd0,     CMD_UNREG, 16'h0001, 16'h0001, 24'h000000, 1'b1, KIND_UNREG_REPLY, ST_NOT_FOUND},
    // all-ones register, then the same pair again
    '{1'b0, 16'd0,     CMD_REG,   16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1, KIND_REG_REPLY,   ST_OK},
    '{1'b0, 16'd0,     CMD_REG,   16'hFFFF, 16'hFFFF, 24'h000000, 1'b1, KIND_REG_REPLY,   ST_DUP},
    // unowned entry, owned zero-period entry, ordinary entry
    '{1'b0, 16'd0,     CMD_REG,   16'h0000, 16'h0000, 24'h000000, 1'b1, KIND_REG_REPLY,   ST_OK},
    '{1'b0, 16'd0,     CMD_REG,   16'h0001, 16'h0000, 24'h000000, 1'b1, KIND_REG_REPLY,   ST_OK},
    '{1'b0, 16'd0,     CMD_REG,   16'h0002, 16'h0005, 24'd100,    1'b1, KIND_REG_REPLY,   ST_OK},
    // two ticks at the reset step
    '{1'b0, 16'd0,     CMD_TICK,  16'h0000, 16'h0000, 24'h000000, 1'b0, KIND_REG_REPLY,   ST_OK},
    '{1'b0, 16'd0,     CMD_TICK,  16'h0000, 16'h0000, 24'h000000, 1'b0, KIND_REG_REPLY,   ST_OK},
    // command three with every field bit set is dropped
    '{1'b0, 16'd0,     CMD_NONE,  16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0, KIND_REG_REPLY,   ST_OK},
    // zero step: only entries already at their period fire
    '{1'b1, 16'd0,     CMD_TICK,  16'h0000, 16'h0000, 24'h000000, 1'b0, KIND_REG_REPLY,   ST_OK},
    '{1'b0, 16'd0,     CMD_TICK,  16'h0000, 16'h0000, 24'h000000, 1'b0, KIND_REG_REPLY,   ST_OK},
    // largest step
    '{1'b1, 16'hFFFF,  CMD_TICK,  16'h0000, 16'h0000, 24'h000000, 1'b0, KIND_REG_REPLY,   ST_OK},
    '{1'b0, 16'd0,     CMD_TICK,  16'h0000, 16'h0000, 24'h000000, 1'b0, KIND_REG_REPLY,   ST_OK},
    // remove from the middle, then the head, then the same pair again
    '{1'b0, 16'd0,     CMD_UNREG, 16'h0000, 16'h0000, 24'h000000, 1'b1, KIND_UNREG_REPLY, ST_OK},
    '{1'b0, 16'd0,     CMD_UNREG, 16'hFFFF, 16'hFFFF, 24'h000000, 1'b1, KIND_UNREG_REPLY, ST_OK},
    '{1'b0, 16'd0,     CMD_UNREG, 16'hFFFF, 16'hFFFF, 24'h000000, 1'b1, KIND_UNREG_REPLY, ST_NOT_FOUND},
    // smallest nonzero step
    '{1'b1, 16'd1,     CMD_TICK,  16'h0000, 16'h0000, 24'h000000, 1'b0, KIND_REG_REPLY,   ST_OK},
    '{1'b0, 16'd0,     CMD_TICK,  16'h0000, 16'h0000, 24'h000000, 1'b0, KIND_REG_REPLY,   ST_OK}
  };

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic [1:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic [1:0]          out_tuser;
  logic                out_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [StepW-1:0]    cfg_data;

  // predictor copy of the timer table
  logic [15:0] tab_owner   [TableDepth];
  logic [15:0] tab_number  [TableDepth];
  logic [23:0] tab_period  [TableDepth];
  logic [23:0] tab_elapsed [TableDepth];
  int          tab_count;
  logic [15:0] step_now;

  result_t awaited_results [$];
  result_t next_results    [$];

  bit no_idle;
  int fail_count;
  int n_items;
  int n_results;
  int n_expiries;
  int n_full;
  int n_steps;

  periodic_software_timer_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(LIMIT);
    $display("timeout at %0t, %0d results still awaited", $time, awaited_results.size());
    $display("Verification failed");
    $finish;
  end

  // receiver backpressure, switched off during the no-idle phase
  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 8);
  end

  function automatic int find_timer(input logic [15:0] o, input logic [15:0] n);
    for (int i = 0; i < tab_count; i++) begin
      if (tab_owner[i] == o && tab_number[i] == n) return i;
    end
    return -1;
  endfunction

  // expected result items of one command; also advances the table copy
  function automatic void predict_timer_results(input cmd_t c, input logic [15:0] o,
                                                input logic [15:0] n, input logic [23:0] p);
    int          hit;
    logic [24:0] sum;
    status_t     st;
    next_results.delete();
    case (c)
      CMD_TICK: begin
        for (int i = 0; i < tab_count; i++) begin
          sum = {1'b0, tab_elapsed[i]} + step_now;
          // counts clamp at the top of the 24-bit range
          if (sum > 25'hFFFFFF) sum = 25'hFFFFFF;
          tab_elapsed[i] = sum[23:0];
          if (tab_owner[i] != 16'h0 && tab_elapsed[i] >= tab_period[i]) begin
            next_results.push_back(result_t'{KIND_EXPIRY, ST_OK, tab_owner[i],
                                             tab_number[i], 1'b0});
            tab_elapsed[i] = 24'h0;
          end
        end
        next_results.push_back(result_t'{KIND_TICK_DONE, ST_OK, 16'h0, 16'h0, 1'b1});
      end
      CMD_REG: begin
        // duplicate check wins over the full check
        if (find_timer(o, n) >= 0) begin
          st = ST_DUP;
        end else if (tab_count >= TableDepth) begin
          st = ST_FULL;
          n_full++;
        end else begin
          tab_owner[tab_count]   = o;
          tab_number[tab_count]  = n;
          tab_period[tab_count]  = p;
          tab_elapsed[tab_count] = 24'h0;
          tab_count++;
          st = ST_OK;
        end
        next_results.push_back(result_t'{KIND_REG_REPLY, st, 16'h0, 16'h0, 1'b1});
      end
      CMD_UNREG: begin
        hit = find_timer(o, n);
        st  = ST_NOT_FOUND;
        if (hit >= 0) begin
          // later entries slide down to close the gap
          for (int i = hit; i < tab_count - 1; i++) begin
            tab_owner[i]   = tab_owner[i+1];
            tab_number[i]  = tab_number[i+1];
            tab_period[i]  = tab_period[i+1];
            tab_elapsed[i] = tab_elapsed[i+1];
          end
          tab_count--;
          st = ST_OK;
        end
        next_results.push_back(result_t'{KIND_UNREG_REPLY, st, 16'h0, 16'h0, 1'b1});
      end
      default: begin
        // command three leaves no trace
      end
    endcase
  endfunction

  // owners and numbers mostly from a small pool so pairs collide
  function automatic logic [15:0] pick_owner();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'h0;
    if (r < 75) return 16'($urandom_range(1, 6));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_number();
    if ($urandom_range(99) < 70) return 16'($urandom_range(0, 5));
    return 16'($urandom);
  endfunction

  // periods mostly a few steps long so timers actually fire
  function automatic logic [23:0] pick_period();
    int r;
    r = $urandom_range(99);
    if (r < 8)  return 24'h0;
    if (r < 20) return 24'($urandom);
    if (r < 28) return 24'hFFFFFF;
    return 24'($urandom_range(1, 8 * step_now + 8));
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(9))
      0:       return 16'h0;
      1:       return 16'h1;
      2:       return 16'hFFFF;
      3, 4, 5: return 16'($urandom_range(1, 100));
      6, 7, 8: return 16'($urandom_range(100, 5000));
      default: return 16'($urandom);
    endcase
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input cmd_t c, input logic [15:0] o, input logic [15:0] n,
                           input logic [23:0] p, input bit typed = 1'b0,
                           input kind_t tk = KIND_REG_REPLY, input status_t ts = ST_OK);
    if (!no_idle && $urandom_range(99) < 8) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tuser  = c;
    in_tdata  = {p, n, o};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_timer_results(c, o, n, p);
    if (typed && c != CMD_NONE) begin
      awaited_results.push_back(result_t'{tk, ts, 16'h0, 16'h0, 1'b1});
    end else begin
      foreach (next_results[i]) awaited_results.push_back(next_results[i]);
    end
    if (c != CMD_NONE) n_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  // step changes only on an idle block: all results drained, then a settle wait
  task automatic write_step(input logic [15:0] v);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    step_now = v;
    n_steps++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result checker: oldest expectation against each accepted result item
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind       = kind_t'(out_tuser);
      got.status     = status_t'(out_tdata[1:0]);
      got.fire_owner = out_tdata[17:2];
      got.fire_id    = out_tdata[33:18];
      got.last       = out_tlast;
      n_results++;
      if (got.kind == KIND_EXPIRY) n_expiries++;
      if (awaited_results.size() == 0) begin
        $display("%0t unexpected item: kind %0d status %0d owner %h id %h last %b",
                 $time, got.kind, got.status, got.fire_owner, got.fire_id, got.last);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected kind %0d status %0d owner %h id %h last %b",
                   $time, want.kind, want.status, want.fire_owner, want.fire_id, want.last);
          $display("%0t           actual   kind %0d status %0d owner %h id %h last %b",
                   $time, got.kind, got.status, got.fire_owner, got.fire_id, got.last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int phase;
    int mode;
    int r;
    int reg_cut;
    int idx;
    int start_items;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_TICK;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    no_idle    = 1'b0;
    fail_count = 0;
    n_items    = 0;
    n_results  = 0;
    n_expiries = 0;
    n_full     = 0;
    n_steps    = 0;
    tab_count  = 0;
    step_now   = TickStepReset;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed walk
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) begin
        write_step(DIRECTED[i].step);
      end else begin
        send_item(DIRECTED[i].cmd, DIRECTED[i].owner, DIRECTED[i].number,
                  DIRECTED[i].period, DIRECTED[i].typed, DIRECTED[i].kind,
                  DIRECTED[i].status);
      end
    end

    start_items = n_items;

    // fill to the top with owned short timers, so one tick fires every entry
    write_step(16'hFFFF);
    while (tab_count < TableDepth) begin
      send_item(CMD_REG, 16'($urandom_range(1, 65535)), 16'($urandom),
                24'($urandom_range(0, 65535)));
    end
    idx = $urandom_range(0, TableDepth - 1);
    send_item(CMD_REG, tab_owner[idx], tab_number[idx], 24'($urandom));
    send_item(CMD_REG, 16'($urandom), 16'($urandom), 24'($urandom));
    send_item(CMD_TICK, 16'($urandom), 16'($urandom), 24'($urandom));
    send_item(CMD_REG, 16'($urandom), 16'($urandom), 24'($urandom));

    // random phases: each picks a step and a command mix
    phase = 0;
    while (n_items - start_items < RAND_ITEMS) begin
      phase++;
      write_step(pick_step());
      // one phase with no idling on either side
      no_idle = (phase == 3);
      mode    = $urandom_range(0, 2);
      reg_cut = (mode == 0) ? 60 : (mode == 1) ? 40 : 20;
      repeat ($urandom_range(15, 40)) begin
        r = $urandom_range(99);
        if (r < reg_cut) begin
          send_item(CMD_REG, pick_owner(), pick_number(), pick_period());
        end else if (r < reg_cut + 22) begin
          send_item(CMD_TICK, 16'($urandom), 16'($urandom), 24'($urandom));
        end else if (r < 95) begin
          if (tab_count > 0 && $urandom_range(3) != 0) begin
            idx = $urandom_range(0, tab_count - 1);
            send_item(CMD_UNREG, tab_owner[idx], tab_number[idx], 24'($urandom));
          end else begin
            send_item(CMD_UNREG, pick_owner(), pick_number(), 24'($urandom));
          end
        end else if ($urandom_range(1) == 0) begin
          send_item(CMD_NONE, 16'($urandom), 16'($urandom), 24'($urandom));
        end else begin
          send_item(CMD_REG, 16'($urandom), 16'($urandom), 24'($urandom));
        end
        // sender holds off until the block has answered everything
        if ($urandom_range(99) < 2) wait_drained();
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d commands, %0d result items (%0d expiries), %0d table-full replies",
             n_items, n_results, n_expiries, n_full);
    $display("tick step rewritten %0d times, including zero, one and the largest value",
             n_steps);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
